// File: rtl/core/stpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpf_pkg
// Types, codes and helpers shared by the site type and polymorphism filter.
// ----------------------------------------------------------------------------
package stpf_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned NumCls = 8;
  localparam int unsigned CntW   = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  typedef enum logic [2:0] {
    CLS_ZERO = 3'd0,
    CLS_ONE  = 3'd1,
    CLS_GAP  = 3'd2,
    CLS_A    = 3'd3,
    CLS_C    = 3'd4,
    CLS_G    = 3'd5,
    CLS_T    = 3'd6,
    CLS_BAD  = 3'd7
  } stpf_cls_e;

  typedef enum logic [2:0] {
    DT_INVALID     = 3'd0,
    DT_OTHER       = 3'd1,
    DT_BINARY      = 3'd2,
    DT_BINARY_GAPS = 3'd3,
    DT_DNA         = 3'd4,
    DT_DNA_GAPS    = 3'd5,
    DT_MISSING     = 3'd6
  } stpf_dtype_e;

  typedef enum logic {
    REG_SINGLETON_FILTER = 1'b0
  } stpf_reg_e;

  localparam logic [CntW-1:0] CntSat = 2'd2;

  typedef logic [CntW-1:0] stpf_cnt_t [NumCls];

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
  } stpf_item_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic fire;
  } stpf_s1_stat_t;

  function automatic stpf_cls_e stpf_classify(input logic [SymW-1:0] ch);
    stpf_cls_e c;
    case (ch) inside
      8'h30:        c = CLS_ZERO;
      8'h31:        c = CLS_ONE;
      8'h2d, 8'h4e: c = CLS_GAP;
      8'h41:        c = CLS_A;
      8'h43:        c = CLS_C;
      8'h47:        c = CLS_G;
      8'h54:        c = CLS_T;
      default:      c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/stpf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpf_in_if
// Character request channel: one site character per request.
// ----------------------------------------------------------------------------
interface stpf_in_if
  import stpf_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/stpf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpf_out_if
// Result request channel: data type and discard flag of one site.
// ----------------------------------------------------------------------------
interface stpf_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] data_type;
  logic       discard;

  modport source (output valid, output data_type, output discard, input ready);
  modport sink   (input valid, input data_type, input discard, output ready);
endinterface
`default_nettype wire

// File: rtl/core/stpf_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpf_in_stage
// Input register for one character; a last character waits here while the
// result register is still occupied.
// ----------------------------------------------------------------------------
module stpf_in_stage
  import stpf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  stpf_in_if.sink      in_i,
  input  wire logic    out_free_i,
  output stpf_item_t   item_o,
  output stpf_s1_stat_t stat_o
);

  logic       valid_q, valid_d;
  stpf_item_t item_q;
  logic       fire;
  logic       take;

  assign fire      = valid_q & (~item_q.last | out_free_i);
  assign in_i.ready = ~valid_q | fire;
  assign take      = in_i.valid & in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.symbol <= in_i.symbol;
      item_q.last   <= in_i.last;
    end
  end

  assign item_o      = item_q;
  assign stat_o.valid = valid_q;
  assign stat_o.last  = item_q.last;
  assign stat_o.fire  = fire;

endmodule
`default_nettype wire

// File: rtl/core/stpf_site_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stpf_site_eval
// Per-site class counters, polymorphism tracking and the result register
// holding data type and discard flag.
// ----------------------------------------------------------------------------
module stpf_site_eval
  import stpf_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire stpf_item_t    item_i,
  input  wire stpf_s1_stat_t stat_i,
  input  wire logic          singleton_filter_i,
  stpf_out_if.source         out_o
);

  stpf_cnt_t   cnt_q, cnt_d, cnt_upd;
  logic        poly_q, poly_d, poly_upd;
  logic        gap_q, gap_d, gap_upd;
  logic        ovalid_q, ovalid_d;
  stpf_dtype_e dtype_q, dtype;
  logic        discard_q, discard;
  stpf_cls_e   cls;
  logic [NumCls-1:0] nz;
  logic        dna_any, dna_two, bin, dna, gaps, poly, single;
  logic        load;

  assign cls  = stpf_classify(item_i.symbol);
  assign load = stat_i.fire & item_i.last;

  always_comb begin
    for (int k = 0; k < NumCls; k++) begin
      cnt_upd[k] = cnt_q[k];
      if ((k == int'(cls)) && (cnt_q[k] != CntSat)) begin
        cnt_upd[k] = cnt_q[k] + 2'd1;
      end
      nz[k] = (cnt_upd[k] != '0);
    end
  end

  assign dna_any = nz[CLS_A] | nz[CLS_C] | nz[CLS_G] | nz[CLS_T];
  assign dna_two = (nz[CLS_A] & (nz[CLS_C] | nz[CLS_G] | nz[CLS_T]))
                 | (nz[CLS_C] & (nz[CLS_G] | nz[CLS_T]))
                 | (nz[CLS_G] & nz[CLS_T]);
  assign gap_upd  = gap_q | ((cls == CLS_GAP) & ~poly_q);
  assign poly_upd = poly_q | (nz[CLS_ZERO] & nz[CLS_ONE]) | dna_two;

  assign gaps = nz[CLS_GAP];
  assign bin  = (nz[CLS_ZERO] | nz[CLS_ONE]) & ~dna_any;
  assign dna  = dna_any & ~nz[CLS_ZERO] & ~nz[CLS_ONE];

  always_comb begin
    if (nz[CLS_BAD]) begin
      dtype = DT_INVALID;
    end else if (bin) begin
      dtype = gaps ? DT_BINARY_GAPS : DT_BINARY;
    end else if (dna) begin
      dtype = gaps ? DT_DNA_GAPS : DT_DNA;
    end else if (gaps) begin
      dtype = DT_MISSING;
    end else begin
      dtype = DT_OTHER;
    end
  end

  always_comb begin
    if (bin) begin
      poly   = nz[CLS_ZERO] & nz[CLS_ONE];
      single = (cnt_upd[CLS_ZERO] == 2'd1) | (cnt_upd[CLS_ONE] == 2'd1);
    end else begin
      poly   = dna_two;
      single = (cnt_upd[CLS_A] == 2'd1) | (cnt_upd[CLS_C] == 2'd1)
             | (cnt_upd[CLS_G] == 2'd1) | (cnt_upd[CLS_T] == 2'd1);
    end
  end

  always_comb begin
    case (dtype) inside
      DT_MISSING: begin
        discard = 1'b1;
      end
      DT_BINARY, DT_BINARY_GAPS, DT_DNA, DT_DNA_GAPS: begin
        if (singleton_filter_i) begin
          discard = ~poly | single | gaps;
        end else begin
          discard = ~poly_upd | gap_upd;
        end
      end
      default: begin
        discard = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    poly_d = poly_q;
    gap_d  = gap_q;
    if (stat_i.fire) begin
      if (item_i.last) begin
        for (int k = 0; k < NumCls; k++) begin
          cnt_d[k] = '0;
        end
        poly_d = 1'b0;
        gap_d  = 1'b0;
      end else begin
        cnt_d  = cnt_upd;
        poly_d = poly_upd;
        gap_d  = gap_upd;
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCls; k++) begin
        cnt_q[k] <= '0;
      end
      poly_q   <= 1'b0;
      gap_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      poly_q   <= poly_d;
      gap_q    <= gap_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dtype_q   <= dtype;
      discard_q <= discard;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.data_type = dtype_q;
  assign out_o.discard   = discard_q;

endmodule
`default_nettype wire

// File: rtl/core/site_type_and_polymorphism_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// site_type_and_polymorphism_filter
// Classifies one alignment site from its characters and flags it for discard.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one ASCII character per request, last marks the final one
//   of a site. out_o carries one result per site: data type and discard.
//   APB register 0 (byte address 0), bit 0: singleton filter enable.
// Throughput: one character per cycle unless a last character is held, set by
//   the single input register and the counter update between it and the result register.
// Result path: the last character passes the input register, then the result
//   register, which raises out_o.valid.
// Stall: while a result waits on out_o, non-last characters keep flowing;
//   a last character is held in the input register until the result
//   register is taken, and in_i.ready drops for that time.
// Reset: all class counters, site flags and the filter enable are cleared,
//   no result is pending.
// ----------------------------------------------------------------------------
module site_type_and_polymorphism_filter
  import stpf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  stpf_in_if.sink               in_i,
  stpf_out_if.source            out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output      logic [DataW-1:0] prdata,
  output      logic             pready
);

  stpf_item_t    item;
  stpf_s1_stat_t s1_stat;
  logic          out_free;
  logic          filt_q, filt_d;
  stpf_reg_e     reg_idx;

  assign out_free = ~out_o.valid | out_o.ready;
  assign pready   = 1'b1;
  assign reg_idx  = stpf_reg_e'(paddr[2]);

  always_comb begin
    filt_d = filt_q;
    if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SINGLETON_FILTER: filt_d = pwdata[0];
        default:              filt_d = filt_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SINGLETON_FILTER: prdata = {{(DataW-1){1'b0}}, filt_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= 1'b0;
    end else begin
      filt_q <= filt_d;
    end
  end

  stpf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .item_o     (item),
    .stat_o     (s1_stat)
  );

  stpf_site_eval u_site_eval (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (item),
    .stat_i             (s1_stat),
    .singleton_filter_i (filt_q),
    .out_o              (out_o)
  );

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_stat.valid && s1_stat.last && out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("last character accepted past a stalled result");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(s1_stat.fire && s1_stat.last))
    else $error("result without a last character");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_stat.valid |-> in_i.ready)
    else $error("input stalled with an empty input register");

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives alignment sites character by character into the site type and
// polymorphism filter and checks each site's data type and discard flag
// against an in-line model of the classifier. Directed sites cover all data
// types but DNA with gaps, the singleton filter and a filter write in the
// middle of a site. Random sites follow, with random source gaps, sink stalls
// and filter settings.
// ----------------------------------------------------------------------------
module testbench;
  import stpf_pkg::*;

  typedef struct {
    stpf_dtype_e dtype;
    logic        discard;
  } site_result_t;

  localparam logic [AddrW-1:0] FilterAddr = AddrW'(4 * int'(REG_SINGLETON_FILTER));

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  stpf_in_if  in_if ();
  stpf_out_if out_if ();

  site_type_and_polymorphism_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // site model state
  logic [1:0]   cls_cnt [NumCls];
  logic         poly_seen;
  logic         gap_early;
  logic         filter_on;
  site_result_t pending_sites [$];

  int error_count = 0;
  int chars_sent  = 0;
  int sites_done  = 0;
  int discards    = 0;
  int type_hits [8];
  int gap_pct     = 25;
  int stall_pct   = 25;
  int stall_left  = 0;

  function automatic stpf_cls_e char_class(input logic [SymW-1:0] ch);
    case (ch)
      "0":      return CLS_ZERO;
      "1":      return CLS_ONE;
      "-", "N": return CLS_GAP;
      "A":      return CLS_A;
      "C":      return CLS_C;
      "G":      return CLS_G;
      "T":      return CLS_T;
      default:  return CLS_BAD;
    endcase
  endfunction

  function automatic int bases_seen();
    int n;
    n = 0;
    for (int k = CLS_A; k <= CLS_T; k++) n += (cls_cnt[k] != 0);
    return n;
  endfunction

  function automatic void clear_site_state();
    foreach (cls_cnt[k]) cls_cnt[k] = '0;
    poly_seen = 1'b0;
    gap_early = 1'b0;
  endfunction

  // advance the model by one accepted character, queue the site result on last
  function automatic void predict_site_char(input logic [SymW-1:0] sym, input logic lst);
    stpf_cls_e    k;
    logic         bin, dna, gaps, poly, single;
    site_result_t r;
    k = char_class(sym);
    if (cls_cnt[k] != CntSat) cls_cnt[k] = cls_cnt[k] + 2'd1;
    if (k == CLS_GAP && !poly_seen) gap_early = 1'b1;
    if ((cls_cnt[CLS_ZERO] != 0 && cls_cnt[CLS_ONE] != 0) || bases_seen() >= 2)
      poly_seen = 1'b1;
    if (!lst) return;

    gaps = cls_cnt[CLS_GAP] != 0;
    bin  = (cls_cnt[CLS_ZERO] != 0 || cls_cnt[CLS_ONE] != 0) && bases_seen() == 0;
    dna  = bases_seen() != 0 && cls_cnt[CLS_ZERO] == 0 && cls_cnt[CLS_ONE] == 0;

    if (cls_cnt[CLS_BAD] != 0) r.dtype = DT_INVALID;
    else if (bin)              r.dtype = gaps ? DT_BINARY_GAPS : DT_BINARY;
    else if (dna)              r.dtype = gaps ? DT_DNA_GAPS : DT_DNA;
    else if (gaps)             r.dtype = DT_MISSING;
    else                       r.dtype = DT_OTHER;

    r.discard = 1'b0;
    if (r.dtype == DT_MISSING) begin
      r.discard = 1'b1;
    end else if (r.dtype != DT_INVALID && r.dtype != DT_OTHER) begin
      if (!filter_on) begin
        r.discard = !poly_seen || gap_early;
      end else begin
        if (bin) begin
          poly   = cls_cnt[CLS_ZERO] != 0 && cls_cnt[CLS_ONE] != 0;
          single = cls_cnt[CLS_ZERO] == 1 || cls_cnt[CLS_ONE] == 1;
        end else begin
          poly   = bases_seen() >= 2;
          single = cls_cnt[CLS_A] == 1 || cls_cnt[CLS_C] == 1 ||
                   cls_cnt[CLS_G] == 1 || cls_cnt[CLS_T] == 1;
        end
        r.discard = !poly || single || gaps;
      end
    end
    pending_sites.push_back(r);
    clear_site_state();
  endfunction

  // result sink: random stall bursts
  always @(negedge clk_i) begin
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
      stall_left = $urandom_range(1, 3);
    out_if.ready <= (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    site_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_sites.size() == 0) begin
        $error("site result with none pending: data_type %0d, discard %0d",
               out_if.data_type, out_if.discard);
        error_count++;
      end else begin
        want = pending_sites.pop_front();
        sites_done++;
        discards += want.discard;
        type_hits[want.dtype]++;
        if (out_if.data_type !== want.dtype) begin
          $error("data_type: expected %0d, got %0d", want.dtype, out_if.data_type);
          error_count++;
        end
        if (out_if.discard !== want.discard) begin
          $error("discard: expected %0d, got %0d", want.discard, out_if.discard);
          error_count++;
        end
      end
    end
  end

  task automatic send_char(input logic [SymW-1:0] sym, input logic lst);
    int n;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      n = $urandom_range(1, 3);
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.symbol <= sym;
    in_if.last   <= lst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_site_char(sym, lst);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_site(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // hold off the source until every site result is in, then let the pipe settle
  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    while (pending_sites.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_filter(input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FilterAddr;
    pwdata  <= DataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    filter_on = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[0] !== val) begin
      $error("singleton_filter readback: expected %0d, got %0d", val, prdata[0]);
      error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [SymW-1:0] pick_gap();
    return $urandom_range(0, 1) ? "-" : "N";
  endfunction

  task automatic send_random_site();
    int              len, kind;
    logic [SymW-1:0] ch, b0, b1, major, minor;
    string           bases, mixed;
    bases = "ACGT";
    mixed = "01-NACGT";
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    kind  = $urandom_range(0, 9);
    b0    = bases[$urandom_range(0, 3)];
    b1    = bases[$urandom_range(0, 3)];
    major = $urandom_range(0, 1) ? "1" : "0";
    minor = (major == "1") ? "0" : "1";
    for (int i = 0; i < len; i++) begin
      case (kind)
        0, 1, 2, 3: begin
          if ($urandom_range(0, 7) == 0)      ch = pick_gap();
          else if ($urandom_range(0, 7) == 0) ch = bases[$urandom_range(0, 3)];
          else                                ch = ($urandom_range(0, 2) == 0) ? b1 : b0;
        end
        4, 5, 6: begin
          if ($urandom_range(0, 7) == 0) ch = pick_gap();
          else                           ch = ($urandom_range(0, 2) == 0) ? minor : major;
        end
        7:       ch = pick_gap();
        8:       ch = mixed[$urandom_range(0, 7)];
        default: ch = SymW'($urandom_range(0, 255));
      endcase
      send_char(ch, i == len - 1);
    end
  endtask

  task automatic test_types_filter_off();
    write_filter(1'b0);
    send_site("01-");
    send_site("-01");
    send_site("GT");
    send_site("N");
    send_site("0A");
    send_site("a");
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b1);
  endtask

  task automatic test_singleton_filter();
    wait_results_done();
    write_filter(1'b1);
    send_site("0011");
    send_site("GGA");
  endtask

  // filter value at the last character decides the site
  task automatic test_filter_write_mid_site();
    send_char("T", 1'b0);
    send_char("T", 1'b0);
    wait_results_done();
    write_filter(1'b0);
    send_char("A", 1'b1);
  endtask

  task automatic test_random_sites();
    int target;
    for (int ph = 0; ph < 6; ph++) begin
      wait_results_done();
      write_filter((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
      gap_pct   = (ph == 2 || ph == 5) ? 0 : 25;
      stall_pct = (ph == 2 || ph == 5) ? 0 : 25;
      target    = chars_sent + 200;
      while (chars_sent < target) begin
        if (ph != 5 && $urandom_range(0, 49) == 0) wait_results_done();
        send_random_site();
      end
    end
  endtask

  initial begin
    #400_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.symbol = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    filter_on    = 1'b0;
    foreach (type_hits[k]) type_hits[k] = 0;
    clear_site_state();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_types_filter_off();
    test_singleton_filter();
    test_filter_write_mid_site();
    test_random_sites();
    wait_results_done();

    $display("%0d characters sent, %0d site results checked, %0d flagged for discard",
             chars_sent, sites_done, discards);
    $display("types: invalid %0d other %0d binary %0d/%0d dna %0d/%0d missing %0d",
             type_hits[DT_INVALID], type_hits[DT_OTHER], type_hits[DT_BINARY],
             type_hits[DT_BINARY_GAPS], type_hits[DT_DNA], type_hits[DT_DNA_GAPS],
             type_hits[DT_MISSING]);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/stpf_pkg.sv
rtl/core/stpf_in_if.sv
rtl/core/stpf_out_if.sv
rtl/core/stpf_in_stage.sv
rtl/core/stpf_site_eval.sv
rtl/core/site_type_and_polymorphism_filter.sv
test/testbench.sv
